// File: rtl/core/dls_pkg.sv
// Shared types, codes and reset values for the display link supervisor.
`default_nettype none
package dls_pkg;

  // Result slots per input item; each slot has a fixed meaning in the step logic.
  localparam int SlotCount = 9;

  localparam logic [15:0] LinkTimeoutReset   = 16'd10000;
  localparam logic [15:0] ProbeIntervalReset = 16'd1000;
  localparam logic [15:0] KnobGapReset       = 16'd50;
  localparam logic [17:0] BatteryIntReset    = 18'd30000;
  localparam logic [15:0] PingIntervalReset  = 16'd3000;
  localparam logic [4:0]  LayerCountReset    = 5'd1;

  typedef enum logic [3:0] {
    MSG_REOPEN  = 4'd0,
    MSG_HELLO   = 4'd1,
    MSG_STATE   = 4'd2,
    MSG_HOLD    = 4'd3,
    MSG_CHAIN   = 4'd4,
    MSG_BATTERY = 4'd5,
    MSG_KNOB    = 4'd6,
    MSG_PING    = 4'd7,
    MSG_LNEXT   = 4'd8,
    MSG_LPREV   = 4'd9,
    MSG_LSET    = 4'd10,
    MSG_IDENT   = 4'd11,
    MSG_NONE    = 4'd12
  } msg_kind_t;

  typedef enum logic [1:0] {
    REQ_BEGIN = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_KNOB  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    CMD_HELLO = 3'd0,
    CMD_PING  = 3'd1,
    CMD_LNEXT = 3'd2,
    CMD_LPREV = 3'd3,
    CMD_LSET  = 3'd4,
    CMD_IDENT = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    REG_LINK_TIMEOUT = 3'd0,
    REG_PROBE_INT    = 3'd1,
    REG_KNOB_GAP     = 3'd2,
    REG_BATTERY_INT  = 3'd3,
    REG_PING_INT     = 3'd4,
    REG_LAYER_COUNT  = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [15:0] link_timeout_ms;
    logic [15:0] probe_interval_ms;
    logic [15:0] knob_gap_ms;
    logic [17:0] battery_interval_ms;
    logic [15:0] ping_interval_ms;
    logic [4:0]  layer_count;
  } cfg_t;

  typedef struct packed {
    logic        link_open;
    logic        link_up_flag;
    logic        beacon_sent;
    logic        pin_order;
    logic [31:0] last_receive_time;
    logic [31:0] next_beacon_time;
    logic [31:0] next_ping_time;
    logic [31:0] next_battery_time;
    logic        knob_waiting;
    logic [7:0]  held_detent;
    logic [31:0] next_knob_time;
  } state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [31:0]        now_ms;
    logic               chain_conflict;
    logic               cmd_valid;
    logic [2:0]         cmd_kind;
    logic signed [15:0] cmd_index;
    logic [1:0]         hold_mask;
    logic [7:0]         knob_detent;
  } item_t;

  typedef struct packed {
    msg_kind_t  kind;
    logic [7:0] arg;
  } slot_t;

  typedef struct packed {
    logic [SlotCount-1:0]             valid;
    slot_t [SlotCount-1:0]            slots;
    logic                             link_up;
  } batch_t;

  // Wrap-aware deadline test: due once now has reached or passed the deadline.
  function automatic logic due(input logic [31:0] now, input logic [31:0] deadline);
    logic [31:0] diff;
    diff = now - deadline;
    return ~diff[31];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/dls_step.sv
// Next-state and result-slot logic for one input item.
`default_nettype none
module dls_step (
  input  wire dls_pkg::state_t cur,
  input  wire dls_pkg::cfg_t   cfg,
  input  wire dls_pkg::item_t  item,
  output dls_pkg::state_t      nxt,
  output dls_pkg::batch_t      batch
);

  // Slots 0..5 carry begin/conflict/command results, slots 6..8 the timed traffic.
  logic [31:0] now;
  logic        cmd_hello;
  logic        timed_out;
  logic        up_after;
  logic        beacon_due;
  logic        battery_due;
  logic [31:0] since_rx;

  always_comb begin
    now       = item.now_ms;
    nxt       = cur;
    batch     = '0;
    cmd_hello = 1'b0;
    timed_out = 1'b0;
    up_after  = cur.link_up_flag;
    beacon_due  = 1'b0;
    battery_due = 1'b0;
    since_rx  = now - cur.last_receive_time;
    for (int i = 0; i < dls_pkg::SlotCount; i++) begin
      batch.slots[i].kind = dls_pkg::MSG_NONE;
    end

    case (item.req_type)
      dls_pkg::REQ_BEGIN: begin
        batch.valid[0]         = 1'b1;
        batch.slots[0].kind    = dls_pkg::MSG_REOPEN;
        nxt.link_open          = 1'b1;
        nxt.pin_order          = 1'b0;
        nxt.link_up_flag       = 1'b0;
        nxt.beacon_sent        = 1'b0;
        nxt.last_receive_time  = now;
        nxt.next_beacon_time   = now;
        nxt.next_battery_time  = now + {14'd0, cfg.battery_interval_ms};
        nxt.knob_waiting       = 1'b0;
        nxt.next_knob_time     = now;
      end
      dls_pkg::REQ_TICK: begin
        if (!cur.link_open) begin
          nxt = cur;
        end else if (item.chain_conflict) begin
          batch.valid[0]        = 1'b1;
          batch.slots[0].kind   = dls_pkg::MSG_REOPEN;
          nxt.pin_order         = 1'b0;
          nxt.link_up_flag      = 1'b0;
          nxt.beacon_sent       = 1'b0;
          nxt.next_beacon_time  = now;
        end else begin
          if (item.cmd_valid) begin
            nxt.last_receive_time = now;
            up_after = 1'b1;
            case (item.cmd_kind)
              dls_pkg::CMD_HELLO: begin
                cmd_hello = 1'b1;
                batch.valid[0] = 1'b1;
                batch.slots[0].kind = dls_pkg::MSG_HELLO;
                batch.valid[1] = 1'b1;
                batch.slots[1].kind = dls_pkg::MSG_STATE;
                batch.valid[2] = item.hold_mask[0];
                batch.slots[2].kind = dls_pkg::MSG_HOLD;
                batch.slots[2].arg  = 8'd1;
                batch.valid[3] = item.hold_mask[1];
                batch.slots[3].kind = dls_pkg::MSG_HOLD;
                batch.slots[3].arg  = 8'd2;
                batch.valid[4] = 1'b1;
                batch.slots[4].kind = dls_pkg::MSG_CHAIN;
                batch.valid[5] = 1'b1;
                batch.slots[5].kind = dls_pkg::MSG_BATTERY;
              end
              dls_pkg::CMD_LNEXT: begin
                batch.valid[0] = (cfg.layer_count > 5'd1);
                batch.slots[0].kind = dls_pkg::MSG_LNEXT;
              end
              dls_pkg::CMD_LPREV: begin
                batch.valid[0] = (cfg.layer_count > 5'd1);
                batch.slots[0].kind = dls_pkg::MSG_LPREV;
              end
              dls_pkg::CMD_LSET: begin
                batch.valid[0] = !item.cmd_index[15] &&
                                 (item.cmd_index[14:0] < {10'd0, cfg.layer_count});
                batch.slots[0].kind = dls_pkg::MSG_LSET;
                batch.slots[0].arg  = item.cmd_index[7:0];
              end
              dls_pkg::CMD_IDENT: begin
                batch.valid[0] = 1'b1;
                batch.slots[0].kind = dls_pkg::MSG_IDENT;
              end
              default: begin
                batch.valid[0] = 1'b0;
              end
            endcase
          end else begin
            // A command in this tick resets the silence, so only a quiet tick can time out.
            timed_out = cur.link_up_flag && (since_rx > {16'd0, cfg.link_timeout_ms});
          end

          if (timed_out) begin
            up_after = 1'b0;
          end
          nxt.link_up_flag = up_after;

          if (!up_after) begin
            nxt.knob_waiting = 1'b0;
            beacon_due = timed_out || dls_pkg::due(now, cur.next_beacon_time);
            if (beacon_due) begin
              if (cur.beacon_sent && !timed_out) begin
                batch.valid[6] = 1'b1;
                batch.slots[6].kind = dls_pkg::MSG_REOPEN;
                batch.slots[6].arg  = {7'd0, ~cur.pin_order};
                nxt.pin_order = ~cur.pin_order;
              end
              batch.valid[7] = 1'b1;
              batch.slots[7].kind = dls_pkg::MSG_HELLO;
              nxt.next_beacon_time = now + {16'd0, cfg.probe_interval_ms};
              nxt.beacon_sent = 1'b1;
            end else begin
              nxt.beacon_sent = cur.beacon_sent && !timed_out;
              nxt.next_beacon_time = timed_out ? now : cur.next_beacon_time;
            end
          end else begin
            if (cur.knob_waiting && dls_pkg::due(now, cur.next_knob_time)) begin
              batch.valid[6] = 1'b1;
              batch.slots[6].kind = dls_pkg::MSG_KNOB;
              batch.slots[6].arg  = cur.held_detent;
              nxt.next_knob_time = now + {16'd0, cfg.knob_gap_ms};
              nxt.knob_waiting = 1'b0;
            end
            // After a hello the deadline is now plus the period, due only for a zero period.
            battery_due = cmd_hello ? (cfg.battery_interval_ms == 18'd0)
                                    : dls_pkg::due(now, cur.next_battery_time);
            if (cmd_hello || battery_due) begin
              nxt.next_battery_time = now + {14'd0, cfg.battery_interval_ms};
            end
            if (battery_due) begin
              batch.valid[7] = 1'b1;
              batch.slots[7].kind = dls_pkg::MSG_BATTERY;
            end
            if (dls_pkg::due(now, cur.next_ping_time)) begin
              batch.valid[8] = 1'b1;
              batch.slots[8].kind = dls_pkg::MSG_PING;
              nxt.next_ping_time = now + {16'd0, cfg.ping_interval_ms};
            end
          end
        end
      end
      dls_pkg::REQ_KNOB: begin
        if (cur.link_up_flag) begin
          nxt.held_detent  = item.knob_detent;
          nxt.knob_waiting = 1'b1;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase

    if (batch.valid == '0) begin
      batch.valid[0] = 1'b1;
      batch.slots[0].kind = dls_pkg::MSG_NONE;
      batch.slots[0].arg  = 8'd0;
    end
    batch.link_up = nxt.link_up_flag;
  end

endmodule
`default_nettype wire

// File: rtl/core/dls_outbuf.sv
// Result buffer that holds one item's result slots and hands them out one beat at a time.
`default_nettype none
module dls_outbuf (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  load,
  input  wire dls_pkg::batch_t batch,
  output logic                 can_load,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [3:0]           msg_kind,
  output logic [7:0]           msg_arg,
  output logic                 link_up,
  output logic                 last
);

  localparam int IdxW = $clog2(dls_pkg::SlotCount);

  logic [dls_pkg::SlotCount-1:0] pending;
  logic [dls_pkg::SlotCount-1:0] pending_next;
  dls_pkg::slot_t [dls_pkg::SlotCount-1:0] slots;
  logic                          link_up_q;
  logic [IdxW-1:0]               cur;
  logic                          beat;

  always_comb begin
    cur = '0;
    for (int i = dls_pkg::SlotCount - 1; i >= 0; i--) begin
      if (pending[i]) begin
        cur = IdxW'(i);
      end
    end
  end

  // Clearing the lowest pending slot moves on to the next result.
  assign pending_next = pending & (pending - {{(dls_pkg::SlotCount-1){1'b0}}, 1'b1});
  assign out_valid    = |pending;
  assign last         = (pending_next == '0);
  assign beat         = out_valid && out_ready;
  assign can_load     = !out_valid || (out_ready && last);
  assign msg_kind     = slots[cur].kind;
  assign msg_arg      = slots[cur].arg;
  assign link_up      = link_up_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (load) begin
      pending <= batch.valid;
    end else if (beat) begin
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots     <= batch.slots;
      link_up_q <= batch.link_up;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/display_link_supervisor_unit.sv
// Top level of the display link supervisor: configuration, link state and result port.
`default_nettype none
// Channel   Handshake               Beat payload
// in        in_valid / in_ready     req_type, now_ms, chain_conflict, cmd_valid, cmd_kind,
//                                   cmd_index, hold_mask, knob_detent
// out       out_valid / out_ready   msg_kind, msg_arg, link_up, last
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An input beat is fully evaluated in the cycle it is accepted: the link state is updated
// at that edge and all results of the item are loaded into the result buffer.
// An item with n results occupies the output port for n beats (one to nine); the next item
// is taken in the same cycle as the final beat, so the single result port sets the rate.
// Reset restores every register default and clears the link state; cfg_ready is always high.
// While any result of the buffered item is still waiting, the input is held off; it opens
// again in the cycle the final beat is taken, so a stalled output stops the input at once.
module display_link_supervisor_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  req_type,
  input  wire  [31:0] now_ms,
  input  wire         chain_conflict,
  input  wire         cmd_valid,
  input  wire  [2:0]  cmd_kind,
  input  wire  signed [15:0] cmd_index,
  input  wire  [1:0]  hold_mask,
  input  wire  [7:0]  knob_detent,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [3:0]  msg_kind,
  output logic [7:0]  msg_arg,
  output logic        link_up,
  output logic        last,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [17:0] cfg_data
);

  dls_pkg::cfg_t   cfg;
  dls_pkg::state_t state;
  dls_pkg::state_t state_next;
  dls_pkg::item_t  item;
  dls_pkg::batch_t batch;
  logic            accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // Configuration registers keep their values across link events; only reset restores them.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_timeout_ms     <= dls_pkg::LinkTimeoutReset;
      cfg.probe_interval_ms   <= dls_pkg::ProbeIntervalReset;
      cfg.knob_gap_ms         <= dls_pkg::KnobGapReset;
      cfg.battery_interval_ms <= dls_pkg::BatteryIntReset;
      cfg.ping_interval_ms    <= dls_pkg::PingIntervalReset;
      cfg.layer_count         <= dls_pkg::LayerCountReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        dls_pkg::REG_LINK_TIMEOUT: cfg.link_timeout_ms     <= cfg_data[15:0];
        dls_pkg::REG_PROBE_INT:    cfg.probe_interval_ms   <= cfg_data[15:0];
        dls_pkg::REG_KNOB_GAP:     cfg.knob_gap_ms         <= cfg_data[15:0];
        dls_pkg::REG_BATTERY_INT:  cfg.battery_interval_ms <= cfg_data;
        dls_pkg::REG_PING_INT:     cfg.ping_interval_ms    <= cfg_data[15:0];
        dls_pkg::REG_LAYER_COUNT:  cfg.layer_count         <= cfg_data[4:0];
        default: begin
          cfg.layer_count <= cfg.layer_count;
        end
      endcase
    end
  end

  assign item.req_type       = req_type;
  assign item.now_ms         = now_ms;
  assign item.chain_conflict = chain_conflict;
  assign item.cmd_valid      = cmd_valid;
  assign item.cmd_kind       = cmd_kind;
  assign item.cmd_index      = cmd_index;
  assign item.hold_mask      = hold_mask;
  assign item.knob_detent    = knob_detent;

  dls_step u_step (
    .cur   (state),
    .cfg   (cfg),
    .item  (item),
    .nxt   (state_next),
    .batch (batch)
  );

  // Link state advances exactly once per accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  dls_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .batch     (batch),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .msg_kind  (msg_kind),
    .msg_arg   (msg_arg),
    .link_up   (link_up),
    .last      (last)
  );

endmodule
`default_nettype wire

// File: bench/display_link_supervisor_unit_test.sv
// Self-checking bench for the display link supervisor: directed and random items scored on the fly.
module display_link_supervisor_unit_test;
  import dls_pkg::*;

  // A run fails if this many cycles pass with no beat on any channel.
  localparam int QuietLimit   = 3000;
  // Cycles allowed after the last owed beat before registers may change.
  localparam int SettleCycles = 12;
  // Cycles to keep watching the result port once nothing more is owed.
  localparam int TailCycles   = 30;

  // Codes the block must accept but that have no entry in the package.
  localparam logic [1:0] REQ_SPARE   = 2'd3;
  localparam logic [2:0] CMD_OTHER   = 3'd6;
  localparam logic [2:0] CMD_SPARE   = 3'd7;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  // One result beat as the block should present it.
  typedef struct packed {
    msg_kind_t  kind;
    logic [7:0] arg;
    logic       link_up;
    logic       last;
  } msg_beat_t;

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic [1:0]         req_type       = '0;
  logic [31:0]        now_ms         = '0;
  logic               chain_conflict = 1'b0;
  logic               cmd_valid      = 1'b0;
  logic [2:0]         cmd_kind       = '0;
  logic signed [15:0] cmd_index      = '0;
  logic [1:0]         hold_mask      = '0;
  logic [7:0]         knob_detent    = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic [3:0]         msg_kind;
  logic [7:0]         msg_arg;
  logic               link_up;
  logic               last;
  logic               cfg_valid      = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index      = '0;
  logic [17:0]        cfg_data       = '0;

  display_link_supervisor_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .now_ms         (now_ms),
    .chain_conflict (chain_conflict),
    .cmd_valid      (cmd_valid),
    .cmd_kind       (cmd_kind),
    .cmd_index      (cmd_index),
    .hold_mask      (hold_mask),
    .knob_detent    (knob_detent),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .msg_kind       (msg_kind),
    .msg_arg        (msg_arg),
    .link_up        (link_up),
    .last           (last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the register file, updated as each write is accepted.
  cfg_t cfg_shadow;

  // Shadow link state. These mirror what the block should hold after each accepted item.
  logic        lk_open;
  logic        lk_up;
  logic        beacon_out;
  logic        pin_sel;
  logic        knob_pending;
  logic [7:0]  knob_pos;
  logic [31:0] last_rx_ms;
  logic [31:0] beacon_at;
  logic [31:0] ping_at;
  logic [31:0] battery_at;
  logic [31:0] knob_at;

  // Messages produced by the item being evaluated, then the queue of beats still owed.
  msg_beat_t step_msgs[$];
  msg_beat_t owed_msgs[$];

  // Bookkeeping for the summary and the verdict.
  int          errors        = 0;
  int          items_sent    = 0;
  int          beats_checked = 0;
  int          regs_written  = 0;
  int          quiet_cycles  = 0;
  logic [15:0] kinds_seen    = '0;

  // Knobs the test tasks turn to shape traffic.
  bit          tx_idle_on  = 1'b0;
  bit          rx_idle_on  = 1'b0;
  int          hold_len    = 0;
  int          hold_seq    = 0;
  logic [31:0] clock_ms    = '0;
  int          ms_step_max = 500;

  task automatic report_error(input string msg);
    errors++;
    $display("ERROR: %s", msg);
  endtask

  // ---------------------------------------------------------------------------------------
  // Link supervisor prediction
  // ---------------------------------------------------------------------------------------

  // A deadline is reached once the wrapped difference now - deadline is non-negative.
  function automatic bit reached(input logic [31:0] now, input logic [31:0] deadline);
    logic [31:0] gap;
    gap = now - deadline;
    return !gap[31];
  endfunction

  // An item never produces more than SlotCount messages; extras are dropped silently.
  function automatic void emit(input msg_kind_t kind, input logic [7:0] arg);
    msg_beat_t b;
    if (step_msgs.size() < SlotCount) begin
      b.kind    = kind;
      b.arg     = arg;
      b.link_up = 1'b0;
      b.last    = 1'b0;
      step_msgs.push_back(b);
    end
  endfunction

  function automatic void open_port(input logic order);
    pin_sel = order;
    lk_open = 1'b1;
    emit(MSG_REOPEN, {7'd0, order});
  endfunction

  // Any valid command proves the companion is alive, whatever its kind.
  function automatic void run_command(input logic [31:0] now, input logic [2:0] kind,
                                      input logic [15:0] idx, input logic [1:0] holds);
    last_rx_ms = now;
    lk_up      = 1'b1;
    case (kind)
      CMD_HELLO: begin
        // A hello is answered with the full status burst.
        emit(MSG_HELLO, 8'd0);
        emit(MSG_STATE, 8'd0);
        if (holds[0]) emit(MSG_HOLD, 8'd1);
        if (holds[1]) emit(MSG_HOLD, 8'd2);
        emit(MSG_CHAIN, 8'd0);
        emit(MSG_BATTERY, 8'd0);
        battery_at = now + {14'd0, cfg_shadow.battery_interval_ms};
      end
      CMD_LNEXT: if (cfg_shadow.layer_count > 5'd1) emit(MSG_LNEXT, 8'd0);
      CMD_LPREV: if (cfg_shadow.layer_count > 5'd1) emit(MSG_LPREV, 8'd0);
      CMD_LSET: begin
        // Negative indexes and indexes past the last layer are dropped.
        if (!idx[15] && idx < {11'd0, cfg_shadow.layer_count}) emit(MSG_LSET, idx[7:0]);
      end
      CMD_IDENT: emit(MSG_IDENT, 8'd0);
      default: ;
    endcase
  endfunction

  // Advances the shadow state by one accepted item and queues the beats it owes.
  function automatic void supervise_step(input item_t it);
    logic [31:0] now;
    now = it.now_ms;
    step_msgs.delete();
    case (it.req_type)
      REQ_BEGIN: begin
        // Opening (or reopening) always restarts probing on pin order zero.
        open_port(1'b0);
        lk_up        = 1'b0;
        beacon_out   = 1'b0;
        last_rx_ms   = now;
        beacon_at    = now;
        battery_at   = now + {14'd0, cfg_shadow.battery_interval_ms};
        knob_pending = 1'b0;
        knob_at      = now;
      end
      REQ_TICK: begin
        if (lk_open) begin
          if (it.chain_conflict) begin
            // The chain bus took our pins: move back to order zero and probe again.
            open_port(1'b0);
            lk_up      = 1'b0;
            beacon_out = 1'b0;
            beacon_at  = now;
          end else begin
            if (it.cmd_valid) run_command(now, it.cmd_kind, it.cmd_index, it.hold_mask);
            if (lk_up && (now - last_rx_ms) > {16'd0, cfg_shadow.link_timeout_ms}) begin
              lk_up      = 1'b0;
              beacon_out = 1'b0;
              beacon_at  = now;
            end
            if (!lk_up) begin
              knob_pending = 1'b0;
              if (reached(now, beacon_at)) begin
                // An unanswered beacon means the other pin order is tried next.
                if (beacon_out) open_port(~pin_sel);
                beacon_at  = now + {16'd0, cfg_shadow.probe_interval_ms};
                beacon_out = 1'b1;
                emit(MSG_HELLO, 8'd0);
              end
            end else begin
              if (knob_pending && reached(now, knob_at)) begin
                knob_at      = now + {16'd0, cfg_shadow.knob_gap_ms};
                knob_pending = 1'b0;
                emit(MSG_KNOB, knob_pos);
              end
              if (reached(now, battery_at)) begin
                battery_at = now + {14'd0, cfg_shadow.battery_interval_ms};
                emit(MSG_BATTERY, 8'd0);
              end
              if (reached(now, ping_at)) begin
                ping_at = now + {16'd0, cfg_shadow.ping_interval_ms};
                emit(MSG_PING, 8'd0);
              end
            end
          end
        end
      end
      REQ_KNOB: begin
        if (lk_up) begin
          knob_pos     = it.knob_detent;
          knob_pending = 1'b1;
        end
      end
      default: ;
    endcase
    // Every item yields at least one beat, and all beats carry the final link state.
    if (step_msgs.size() == 0) emit(MSG_NONE, 8'd0);
    foreach (step_msgs[i]) begin
      step_msgs[i].link_up = lk_up;
      step_msgs[i].last    = (i == step_msgs.size() - 1);
      owed_msgs.push_back(step_msgs[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------------------

  // Offers one item. Inputs change on the falling edge; acceptance is seen on the rising
  // edge. The valid stays high after acceptance so that a back-to-back item can follow
  // without a low glitch; every caller reaches a falling edge that either drives the next
  // item or lowers the valid before the next rising edge.
  task automatic send_item(input item_t it);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type       <= it.req_type;
    now_ms         <= it.now_ms;
    chain_conflict <= it.chain_conflict;
    cmd_valid      <= it.cmd_valid;
    cmd_kind       <= it.cmd_kind;
    cmd_index      <= it.cmd_index;
    hold_mask      <= it.hold_mask;
    knob_detent    <= it.knob_detent;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    supervise_step(it);
    items_sent++;
  endtask

  // The sender stops and waits until every owed beat has been taken.
  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_msgs.size() != 0) @(posedge clk);
  endtask

  // Registers only change with the block idle. Every item owes a beat, but a few spare
  // cycles are left anyway before touching the register file.
  task automatic wait_idle();
    pause_until_drained();
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [17:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      REG_LINK_TIMEOUT: cfg_shadow.link_timeout_ms     = value[15:0];
      REG_PROBE_INT:    cfg_shadow.probe_interval_ms   = value[15:0];
      REG_KNOB_GAP:     cfg_shadow.knob_gap_ms         = value[15:0];
      REG_BATTERY_INT:  cfg_shadow.battery_interval_ms = value;
      REG_PING_INT:     cfg_shadow.ping_interval_ms    = value[15:0];
      REG_LAYER_COUNT:  cfg_shadow.layer_count         = value[4:0];
      default: ;  // indexes past the register list change nothing
    endcase
    regs_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Loads a full register set, plus one write to an index that does not exist.
  task automatic apply_settings(input logic [15:0] timeout, input logic [15:0] probe,
                                input logic [15:0] knob_gap, input logic [17:0] battery,
                                input logic [15:0] ping, input logic [4:0] layers);
    wait_idle();
    write_reg(REG_LINK_TIMEOUT, {2'd0, timeout});
    write_reg(REG_PROBE_INT, {2'd0, probe});
    write_reg(REG_KNOB_GAP, {2'd0, knob_gap});
    write_reg(REG_BATTERY_INT, battery);
    write_reg(REG_PING_INT, {2'd0, ping});
    write_reg(REG_LAYER_COUNT, {13'd0, layers});
    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 18'($urandom));
  endtask

  function automatic item_t build(input logic [1:0] req, input logic [31:0] now,
                                  input logic conflict, input logic cmd_on,
                                  input logic [2:0] kind, input logic [15:0] idx,
                                  input logic [1:0] holds, input logic [7:0] detent);
    item_t it;
    it.req_type       = req;
    it.now_ms         = now;
    it.chain_conflict = conflict;
    it.cmd_valid      = cmd_on;
    it.cmd_kind       = kind;
    it.cmd_index      = idx;
    it.hold_mask      = holds;
    it.knob_detent    = detent;
    return it;
  endfunction

  // Mostly ticks on a forward-moving clock with a fair share of commands, so the link
  // actually comes up and the periodic messages fire. Big jumps force timeouts, small
  // backward steps and wild jumps exercise the wrap-aware deadline compares, and a few
  // begins, spare request codes and pin conflicts break the sequence.
  function automatic item_t random_item();
    item_t it;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 4)       it.req_type = REQ_BEGIN;
    else if (pick < 7)  it.req_type = REQ_SPARE;
    else if (pick < 27) it.req_type = REQ_KNOB;
    else                it.req_type = REQ_TICK;
    pick = $urandom_range(0, 99);
    if (pick < 84)      clock_ms = clock_ms + $urandom_range(0, ms_step_max);
    else if (pick < 92) clock_ms = clock_ms + $urandom_range(0, 80000);
    else if (pick < 96) clock_ms = clock_ms - $urandom_range(0, 400);
    else                clock_ms = $urandom;
    it.now_ms         = clock_ms;
    it.chain_conflict = ($urandom_range(0, 99) < 3);
    it.cmd_valid      = ($urandom_range(0, 99) < 40);
    it.cmd_kind       = 3'($urandom_range(0, 7));
    it.cmd_index      = $urandom_range(0, 1) ? 16'($urandom_range(0, 20)) : 16'($urandom);
    it.hold_mask      = 2'($urandom_range(0, 3));
    it.knob_detent    = 8'($urandom);
    return it;
  endfunction

  // Random traffic that starts with a begin; idling on each side is redrawn now and then
  // so that stretches with and without gaps both occur.
  task automatic run_random(input int count);
    send_item(build(REQ_BEGIN, clock_ms, 1'b0, 1'b0, CMD_HELLO, 16'd0, 2'd0, 8'd0));
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        tx_idle_on = $urandom_range(0, 1);
        rx_idle_on = $urandom_range(0, 1);
      end
      send_item(random_item());
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Hand-picked items: activity before the port is open, the probe and pin swap, the hello burst
  // with both holds, the layer commands with one layer and with sixteen, the other command kinds,
  // layer set bounds, a silence timeout, a pin conflict, a second begin, and the time extremes.
  task automatic test_directed();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_item(build(REQ_TICK, 32'd0, 1'b0, 1'b1, CMD_HELLO, 16'd0, 2'd3, 8'd0));
    send_item(build(REQ_KNOB, 32'd2, 1'b0, 1'b0, CMD_HELLO, 16'd0, 2'd0, 8'hA5));
    send_item(build(REQ_SPARE, 32'd5, 1'b1, 1'b1, CMD_IDENT, 16'd3, 2'd3, 8'hFF));
    send_item(build(REQ_BEGIN, 32'd100, 1'b0, 1'b0, CMD_HELLO, 16'd0, 2'd0, 8'd0));
    send_item(build(REQ_TICK, 32'd100, 1'b0, 1'b0, CMD_HELLO, 16'd0, 2'd0, 8'd0));
    send_item(build(REQ_TICK, 32'd1100, 1'b0, 1'b0, CMD_HELLO, 16'd0, 2'd0, 8'd0));
    send_item(build(REQ_TICK, 32'd1200, 1'b0, 1'b1, CMD_HELLO, 16'd0, 2'd3, 8'd0));
    send_item(build(REQ_KNOB, 32'd1205, 1'b0, 1'b0, CMD_HELLO, 16'd0, 2'd0, 8'hFF));
    send_item(build(REQ_TICK, 32'd1210, 1'b0, 1'b1, CMD_PING, 16'd0, 2'd0, 8'd0));
    // With a single layer the step commands are dropped but layer zero may still be set.
    send_item(build(REQ_TICK, 32'd1220, 1'b0, 1'b1, CMD_LNEXT, 16'd0, 2'd0, 8'd0));
    send_item(build(REQ_TICK, 32'd1230, 1'b0, 1'b1, CMD_LPREV, 16'd0, 2'd0, 8'd0));
    send_item(build(REQ_TICK, 32'd1240, 1'b0, 1'b1, CMD_LSET, 16'd0, 2'd0, 8'd0));
    apply_settings(LinkTimeoutReset, ProbeIntervalReset, KnobGapReset, BatteryIntReset,
                   PingIntervalReset, 5'd16);
    send_item(build(REQ_TICK, 32'd1250, 1'b0, 1'b1, CMD_LNEXT, 16'd0, 2'd0, 8'd0));
    send_item(build(REQ_TICK, 32'd1260, 1'b0, 1'b1, CMD_LPREV, 16'd0, 2'd0, 8'd0));
    send_item(build(REQ_TICK, 32'd1270, 1'b0, 1'b1, CMD_LSET, 16'd15, 2'd0, 8'd0));
    send_item(build(REQ_TICK, 32'd1280, 1'b0, 1'b1, CMD_LSET, 16'd16, 2'd0, 8'd0));
    send_item(build(REQ_TICK, 32'd1290, 1'b0, 1'b1, CMD_LSET, 16'h8000, 2'd0, 8'd0));
    send_item(build(REQ_TICK, 32'd1300, 1'b0, 1'b1, CMD_LSET, 16'h7FFF, 2'd0, 8'd0));
    send_item(build(REQ_TICK, 32'd1310, 1'b0, 1'b1, CMD_IDENT, 16'd0, 2'd0, 8'd0));
    send_item(build(REQ_TICK, 32'd1320, 1'b0, 1'b1, CMD_OTHER, 16'd0, 2'd0, 8'd0));
    send_item(build(REQ_TICK, 32'd1330, 1'b0, 1'b1, CMD_SPARE, 16'd0, 2'd0, 8'd0));
    // Long silence drops the link; the knob that follows is ignored.
    send_item(build(REQ_TICK, 32'd25000, 1'b0, 1'b0, CMD_HELLO, 16'd0, 2'd0, 8'd0));
    send_item(build(REQ_KNOB, 32'd25050, 1'b0, 1'b0, CMD_HELLO, 16'd0, 2'd0, 8'd0));
    send_item(build(REQ_TICK, 32'd25100, 1'b1, 1'b1, CMD_HELLO, 16'd0, 2'd3, 8'd0));
    send_item(build(REQ_BEGIN, 32'd25200, 1'b0, 1'b0, CMD_HELLO, 16'd0, 2'd0, 8'd0));
    send_item(build(REQ_TICK, 32'hFFFF_FFFF, 1'b0, 1'b1, CMD_HELLO, 16'd0, 2'd2, 8'd0));
  endtask

  // Moderate timer settings, with gaps coming and going on both sides.
  task automatic test_random_traffic();
    apply_settings(16'd4000, 16'd700, 16'd120, 18'd9000, 16'd1500, 5'd5);
    clock_ms    = 32'd40000;
    ms_step_max = 500;
    run_random(130);
  endtask

  // Every timer at zero or one: nearly every tick has messages due, so items produce long
  // bursts of beats and the result port sets the pace.
  task automatic test_fastest_timers();
    apply_settings(16'd1, 16'd1, 16'd0, 18'd1, 16'd1, 5'd1);
    clock_ms    = $urandom;
    ms_step_max = 3;
    run_random(45);
  endtask

  // Every timer at its maximum, starting just short of the 32-bit wrap of the clock.
  task automatic test_slowest_timers();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 18'h3FFFF, 16'hFFFF, 5'd16);
    clock_ms    = 32'hFFFF_0000;
    ms_step_max = 6000;
    run_random(45);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering items back
  // to back, so the block fills and has to refuse input. The sender then stops until the
  // result queue has fully drained before sending more.
  task automatic test_stall_and_drain();
    apply_settings(16'd3000, 16'd400, 16'd20, 18'd5000, 16'd700, 5'd8);
    clock_ms    = $urandom;
    ms_step_max = 300;
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    hold_len    = 400;
    hold_seq++;
    send_item(build(REQ_BEGIN, clock_ms, 1'b0, 1'b0, CMD_HELLO, 16'd0, 2'd0, 8'd0));
    for (int i = 0; i < 30; i++) send_item(random_item());
    pause_until_drained();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int i = 0; i < 25; i++) send_item(random_item());
  endtask

  // ---------------------------------------------------------------------------------------
  // Result port: ready pattern and scoring
  // ---------------------------------------------------------------------------------------

  // One process owns out_ready. Each accepted beat is scored against the oldest owed beat
  // on the rising edge; the ready for the next cycle is set on the falling edge, either
  // from a long hold-off requested by a test or from a per-beat random wait.
  initial begin : result_port
    msg_beat_t want;
    int        stall;
    int        hold_left;
    int        hold_seen;
    stall     = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        beats_checked++;
        kinds_seen[msg_kind] = 1'b1;
        if (owed_msgs.size() == 0) begin
          report_error($sformatf("beat %0d: kind %0d arrived with nothing owed",
                                 beats_checked, msg_kind));
        end else begin
          want = owed_msgs.pop_front();
          if (msg_kind !== want.kind)
            report_error($sformatf("beat %0d: msg_kind %0d, expected %0d (%s)",
                                   beats_checked, msg_kind, want.kind, want.kind.name()));
          if (msg_arg !== want.arg)
            report_error($sformatf("beat %0d: msg_arg %0d, expected %0d",
                                   beats_checked, msg_arg, want.arg));
          if (link_up !== want.link_up)
            report_error($sformatf("beat %0d: link_up %b, expected %b",
                                   beats_checked, link_up, want.link_up));
          if (last !== want.last)
            report_error($sformatf("beat %0d: last %b, expected %b",
                                   beats_checked, last, want.last));
        end
        stall = rx_idle_on ? $urandom_range(0, 19) : 0;
      end
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without a beat on any channel means the block has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("ERROR: no beat for %0d cycles, %0d result beats still owed",
               QuietLimit, owed_msgs.size());
      $display("display_link_supervisor_unit_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    // Shadow state starts at the block's reset values.
    cfg_shadow.link_timeout_ms     = LinkTimeoutReset;
    cfg_shadow.probe_interval_ms   = ProbeIntervalReset;
    cfg_shadow.knob_gap_ms         = KnobGapReset;
    cfg_shadow.battery_interval_ms = BatteryIntReset;
    cfg_shadow.ping_interval_ms    = PingIntervalReset;
    cfg_shadow.layer_count         = LayerCountReset;
    lk_open      = 1'b0;
    lk_up        = 1'b0;
    beacon_out   = 1'b0;
    pin_sel      = 1'b0;
    knob_pending = 1'b0;
    knob_pos     = '0;
    last_rx_ms   = '0;
    beacon_at    = '0;
    ping_at      = '0;
    battery_at   = '0;
    knob_at      = '0;

    // Reset is held from the start and released on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic();
    test_fastest_timers();
    test_slowest_timers();
    test_stall_and_drain();

    // Let every owed beat arrive, then watch a little longer for stray beats.
    pause_until_drained();
    repeat (TailCycles) @(posedge clk);

    $display("Summary: %0d items sent, %0d result beats scored, %0d register writes.",
             items_sent, beats_checked, regs_written);
    $display("Summary: %0d of %0d message kinds seen, %0d mismatches.",
             $countones(kinds_seen), int'(MSG_NONE) + 1, errors);
    if (errors == 0) begin
      $display("display_link_supervisor_unit_test: PASS");
    end else begin
      $display("display_link_supervisor_unit_test: FAIL");
    end
    $finish;
  end

endmodule
